>>> sv/spq_pkg.sv
package spq_pkg;

	localparam int CAPACITY     = 16;
	localparam int KEY_WIDTH    = 32;
	localparam int HANDLE_WIDTH = 16;
	localparam int CNT_W        = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_REM  = 2'd1,
		CMD_PEEK = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_e;

	typedef struct packed {
		cmd_e                    command;
		logic [KEY_WIDTH-1:0]    item_key;
		logic [HANDLE_WIDTH-1:0] item_handle;
	} req_t;

	typedef struct packed {
		status_e                 status;
		logic                    head_valid;
		logic [KEY_WIDTH-1:0]    head_key;
		logic [HANDLE_WIDTH-1:0] head_handle;
		logic [CNT_W-1:0]        entry_count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_WIDTH-1:0]    key;
		logic [HANDLE_WIDTH-1:0] handle;
	} entry_t;

	// broadcast to every cell for one transaction
	typedef struct packed {
		logic                    enq;
		logic                    rem;
		logic [KEY_WIDTH-1:0]    key;
		logic [HANDLE_WIDTH-1:0] handle;
	} ctl_t;

endpackage

>>> sv/spq_cell.sv
module spq_cell (
	input  logic          clk,
	input  spq_pkg::ctl_t ctl,
	input  logic          occ,
	input  logic          first,
	input  logic          left_move,
	input  spq_pkg::entry_t left_entry,
	input  spq_pkg::entry_t right_entry,
	input  logic          hit_in,
	output spq_pkg::entry_t entry,
	output logic          move,
	output logic          hit_out
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_nxt;
	logic            cond;
	logic            match;

	assign entry = entry_q;

	// head is displaced only by a strictly smaller key
	assign cond    = first ? (ctl.key < entry_q.key) : (entry_q.key >= ctl.key);
	assign move    = ctl.enq && occ && cond;
	assign match   = occ && (entry_q.handle == ctl.handle);
	assign hit_out = hit_in || match;

	always_comb begin
		entry_nxt = entry_q;
		if (ctl.enq) begin
			if (left_move && !first) begin
				entry_nxt = left_entry;
			end else if (move || !occ) begin
				entry_nxt.key    = ctl.key;
				entry_nxt.handle = ctl.handle;
			end
		end else if (ctl.rem) begin
			// close the gap: everything from the first match onward shifts toward the head
			if (hit_out) begin
				entry_nxt = right_entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

endmodule

>>> sv/sorted_priority_queue_unit.sv
// The result of a transaction is registered and offered on rsp in the cycle after it is accepted.
// Throughput: one transaction per cycle while the response is not stalled; every cell of the chain shifts, inserts or
// holds in that single cycle, and the entry count register updates alongside.
// Reset clears the entry count and the response valid; cell contents stay undefined
// and are never read until written.
module sorted_priority_queue_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic [spq_pkg::CNT_W-1:0] count_nxt;
	logic                      rsp_valid_q;
	spq_pkg::status_e          status_q;
	spq_pkg::status_e          status_nxt;
	logic                      accept;
	logic                      full;
	logic                      found;
	spq_pkg::ctl_t             ctl;

	spq_pkg::entry_t entries [spq_pkg::CAPACITY];
	logic            moves   [spq_pkg::CAPACITY];
	logic            hits    [spq_pkg::CAPACITY+1];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
	assign found     = hits[spq_pkg::CAPACITY];
	assign hits[0]   = 1'b0;

	// cell controls depend only on the request, the stall and the count, never on the match chain
	always_comb begin
		ctl.enq    = accept && (req.command == spq_pkg::CMD_ENQ) && !full;
		ctl.rem    = accept && (req.command == spq_pkg::CMD_REM);
		ctl.key    = req.item_key;
		ctl.handle = req.item_handle;
	end

	always_comb begin
		status_nxt = spq_pkg::ST_OK;
		count_nxt  = count_q;
		unique case (req.command)
			spq_pkg::CMD_ENQ: begin
				if (full) begin
					status_nxt = spq_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			spq_pkg::CMD_REM: begin
				if (found) begin
					count_nxt = count_q - 1'b1;
				end else begin
					status_nxt = spq_pkg::ST_MISSING;
				end
			end
			default: begin
				status_nxt = spq_pkg::ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
		logic            occ;
		logic            left_move;
		spq_pkg::entry_t left_entry;
		spq_pkg::entry_t right_entry;

		assign occ = (spq_pkg::CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_move  = 1'b0;
			assign left_entry = entries[0];
		end else begin : g_rest
			assign left_move  = moves[i-1];
			assign left_entry = entries[i-1];
		end

		if (i == spq_pkg::CAPACITY - 1) begin : g_last
			assign right_entry = entries[i];
		end else begin : g_mid
			assign right_entry = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ),
			.first       (i == 0),
			.left_move   (left_move),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.hit_in      (hits[i]),
			.entry       (entries[i]),
			.move        (moves[i]),
			.hit_out     (hits[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
		end
	end

	// cells and count hold while the response is stalled, so the payload stays put
	assign rsp_valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.head_valid   = (count_q != '0);
	assign rsp.head_key     = rsp.head_valid ? entries[0].key : '0;
	assign rsp.head_handle  = rsp.head_valid ? entries[0].handle : '0;
	assign rsp.entry_count  = count_q;

endmodule

>>> test/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;
	import spq_pkg::*;

	localparam int   LIMIT     = 200000;
	localparam int   RAND_ITEMS = 900;
	localparam cmd_e CMD_SPARE = cmd_e'(2'd3);

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t e;
	} dir_row_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic [KEY_WIDTH-1:0]    mirror_keys[CAPACITY];
	logic [HANDLE_WIDTH-1:0] mirror_handles[CAPACITY];
	int                      mirror_count = 0;

	rsp_t     expected_heads[$];
	dir_row_t dir_rows[$];
	int       errors  = 0;
	int       cycles  = 0;
	int       gap_pct = 29;

	sorted_priority_queue_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// advance the mirrored queue by one transaction and return the result it shows
	function automatic rsp_t predict_step(req_t r);
		rsp_t res;
		int   pos;
		int   i;
		res = '0;
		res.status = ST_OK;
		case (r.command)
			CMD_ENQ: begin
				if (mirror_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					// the head moves only for a strictly smaller key
					if (mirror_count == 0 || r.item_key < mirror_keys[0]) begin
						pos = 0;
					end else begin
						pos = 1;
						while (pos < mirror_count && mirror_keys[pos] < r.item_key)
							pos++;
					end
					for (i = mirror_count; i > pos; i--) begin
						mirror_keys[i]    = mirror_keys[i-1];
						mirror_handles[i] = mirror_handles[i-1];
					end
					mirror_keys[pos]    = r.item_key;
					mirror_handles[pos] = r.item_handle;
					mirror_count++;
				end
			end
			CMD_REM: begin
				pos = 0;
				while (pos < mirror_count && mirror_handles[pos] != r.item_handle)
					pos++;
				if (pos >= mirror_count) begin
					res.status = ST_MISSING;
				end else begin
					for (i = pos; i + 1 < mirror_count; i++) begin
						mirror_keys[i]    = mirror_keys[i+1];
						mirror_handles[i] = mirror_handles[i+1];
					end
					mirror_count--;
				end
			end
			default: ;
		endcase
		if (mirror_count > 0) begin
			res.head_valid  = 1'b1;
			res.head_key    = mirror_keys[0];
			res.head_handle = mirror_handles[0];
		end
		res.entry_count = CNT_W'(mirror_count);
		return res;
	endfunction

	task automatic add_row(cmd_e c, logic [KEY_WIDTH-1:0] k, logic [HANDLE_WIDTH-1:0] h,
			bit typed, status_e s, logic hv, logic [KEY_WIDTH-1:0] hk,
			logic [HANDLE_WIDTH-1:0] hh, int cnt);
		dir_row_t row;
		row.r.command     = c;
		row.r.item_key    = k;
		row.r.item_handle = h;
		row.typed         = typed;
		row.e.status      = s;
		row.e.head_valid  = hv;
		row.e.head_key    = hk;
		row.e.head_handle = hh;
		row.e.entry_count = CNT_W'(cnt);
		dir_rows.push_back(row);
	endtask

	// offer one transaction, hold it through stalls, record its expectation on acceptance
	task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
		rsp_t predicted;
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = predict_step(r);
		expected_heads.push_back(typed ? typed_rsp : predicted);
	endtask

	task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	function automatic logic [HANDLE_WIDTH-1:0] pick_handle();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40)
			return HANDLE_WIDTH'($urandom_range(15));
		else if (sel < 45)
			return '0;
		else if (sel < 50)
			return '1;
		return HANDLE_WIDTH'($urandom);
	endfunction

	function automatic logic [KEY_WIDTH-1:0] pick_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 25)
			return KEY_WIDTH'($urandom_range(7));
		else if (sel < 30)
			return '0;
		else if (sel < 35)
			return '1;
		return KEY_WIDTH'($urandom);
	endfunction

	// receiver: random stall, check every accepted result against the oldest expectation
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_heads.size() == 0) begin
					$display("%0t: unexpected result %0h", $time, rsp);
					errors++;
				end else begin
					exp_r = expected_heads.pop_front();
					compare_field("status", exp_r.status, rsp.status);
					compare_field("head_valid", exp_r.head_valid, rsp.head_valid);
					compare_field("head_key", exp_r.head_key, rsp.head_key);
					compare_field("head_handle", exp_r.head_handle, rsp.head_handle);
					compare_field("entry_count", exp_r.entry_count, rsp.entry_count);
				end
			end
			rsp_stall <= ($urandom_range(99) < gap_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		req_t r;
		rsp_t none;
		int   mode;
		int   sel;
		none = '0;

		// empty queue, its error cases and the first enqueues
		add_row(CMD_PEEK, '0, '0, 1, ST_OK, 0, '0, '0, 0);
		add_row(CMD_REM, '0, '0, 1, ST_MISSING, 0, '0, '0, 0);
		add_row(CMD_SPARE, '1, '1, 1, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, 32'h8000_0000, 16'h0001, 1, ST_OK, 1, 32'h8000_0000, 16'h0001, 1);
		add_row(CMD_ENQ, '1, '1, 1, ST_OK, 1, 32'h8000_0000, 16'h0001, 2);
		// equal key stays behind the head
		add_row(CMD_ENQ, 32'h8000_0000, 16'h0002, 1, ST_OK, 1, 32'h8000_0000, 16'h0001, 3);
		add_row(CMD_ENQ, '0, '0, 1, ST_OK, 1, '0, '0, 4);
		add_row(CMD_ENQ, '0, 16'h5555, 1, ST_OK, 1, '0, '0, 5);
		add_row(CMD_REM, '0, '0, 1, ST_OK, 1, '0, 16'h5555, 4);
		add_row(CMD_REM, '0, 16'h1234, 1, ST_MISSING, 1, '0, 16'h5555, 4);
		add_row(CMD_PEEK, '1, '1, 1, ST_OK, 1, '0, 16'h5555, 4);
		// fill to capacity with ties and extremes
		add_row(CMD_ENQ, 32'hAAAA_AAAA, 16'hAAAA, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, 32'h5555_5555, 16'hFFFF, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, '1, 16'h0001, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, '0, 16'h7FFF, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, 32'h7FFF_FFFF, 16'h8000, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, 32'h0000_0001, 16'h0002, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, 32'h8000_0000, 16'h00FF, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, 32'hFFFF_FFFE, 16'hFF00, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, 32'h0000_0001, 16'h0003, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, 32'h1234_5678, 16'h1234, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, '0, 16'h0000, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, 32'hDEAD_BEEF, 16'hBEEF, 0, ST_OK, 0, '0, '0, 0);
		add_row(CMD_ENQ, 32'h0000_0002, 16'h0004, 1, ST_FULL, 1, '0, 16'h5555, 16);
		add_row(CMD_REM, '0, 16'h5555, 0, ST_OK, 0, '0, '0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			gap_pct = (n >= 500 && n < 650) ? 0 : 29;
			if (n == 450) begin
				// drain everything in flight before going on
				req_valid <= 1'b0;
				@(posedge clk);
				while (expected_heads.size() != 0)
					@(posedge clk);
			end
			// alternate fill-heavy, drain-heavy and balanced stretches
			mode = (n / 75) % 3;
			sel  = $urandom_range(99);
			r.item_key    = pick_key();
			r.item_handle = pick_handle();
			if (sel < 5)
				r.command = CMD_PEEK;
			else if (sel < 8)
				r.command = CMD_SPARE;
			else if (sel < (mode == 0 ? 75 : (mode == 1 ? 30 : 54)))
				r.command = CMD_ENQ;
			else
				r.command = CMD_REM;
			if (r.command == CMD_REM && mirror_count > 0 && $urandom_range(99) < 65)
				r.item_handle = mirror_handles[$urandom_range(mirror_count - 1)];
			send_request(r, 0, none);
		end

		req_valid <= 1'b0;
		gap_pct = 29;
		while (expected_heads.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0 && expected_heads.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
